>>> sv/tfpd_pkg.sv
// Package for the floating-point predictor decoder.
// Holds the default row size, register indexes, field widths and the
// store request type shared by the top level and the plane store.
package tfpd_pkg;

  localparam int MaxRowSamples = 512;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 10;
  localparam int RowSamplesWidth = 10;

  localparam logic [CfgIndexWidth-1:0] CFG_ROW_SAMPLES = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_USE_PRED    = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_BYTE_ORDER  = 2'd2;
  // Index beyond the register list; a write to it changes nothing.
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE       = 2'd3;

  localparam logic [RowSamplesWidth-1:0] ROW_SAMPLES_RESET = 10'd512;

  localparam logic [1:0] PLANE_TOP  = 2'd0;
  localparam logic [1:0] PLANE_MID  = 2'd1;
  localparam logic [1:0] PLANE_LOW  = 2'd2;
  localparam logic [1:0] PLANE_LAST = 2'd3;

  // One access to the plane store in the cycle of a transfer.
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [1:0] plane;
  } store_req_t;

endpackage

>>> sv/tfpd_plane_store.sv
// Per-sample store of the three upper byte planes of a row.
// Byte-lane writes, one registered read port. Depends on tfpd_pkg.
module tfpd_plane_store #(
  parameter int Depth = tfpd_pkg::MaxRowSamples,
  parameter int AddrWidth = 9
) (
  input  logic                  clk_i,
  input  tfpd_pkg::store_req_t  req_i,
  input  logic [AddrWidth-1:0]  addr_i,
  input  logic [7:0]            data_i,
  output logic [23:0]           rdata_o
);

  logic [23:0] mem [Depth];
  logic [23:0] rdata_q;

  // Each plane owns one byte lane; the top plane sits in the upper lane.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      case (req_i.plane)
        tfpd_pkg::PLANE_TOP: mem[addr_i][23:16] <= data_i;
        tfpd_pkg::PLANE_MID: mem[addr_i][15:8]  <= data_i;
        default:             mem[addr_i][7:0]   <= data_i;
      endcase
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/tiff_float_predictor_decode.sv
// A result passes from the transfer of the byte that completes it through the store read stage
// and then the output register.
// Throughput: one byte per cycle; a result follows every fourth byte (plain words) or every
// byte of a row's last plane (predictor). The input stalls only for a register write or for
// a result held up at the output. Reset clears control state and the registers; the store
// needs no clearing pass. Depends on tfpd_pkg and tfpd_plane_store.
module tiff_float_predictor_decode #(
  parameter int MAX_ROW_SAMPLES = tfpd_pkg::MaxRowSamples
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [31:0]                        sample_bits_o,
  output logic                               row_end_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tfpd_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [tfpd_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int AW = (MAX_ROW_SAMPLES > 1) ? $clog2(MAX_ROW_SAMPLES) : 1;
  localparam int WW = $clog2(MAX_ROW_SAMPLES + 1);
  localparam int CW = (WW > tfpd_pkg::RowSamplesWidth) ? WW : tfpd_pkg::RowSamplesWidth;

  // Configuration.
  logic [tfpd_pkg::RowSamplesWidth-1:0] row_samples_q;
  logic use_pred_q, msb_first_q;

  // Row state.
  logic [7:0]    prev_byte_q, prev_byte_d;
  logic [1:0]    plane_q, plane_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [23:0]   gather_q, gather_d;

  // Read stage and output register.
  logic        s1_valid_q, s1_pred_q, s1_last_q;
  logic [31:0] s1_word_q;
  logic        out_valid_q, row_end_q;
  logic [31:0] sample_q;

  logic        accept, s1_advance, cfg_write, result;
  logic [WW-1:0] width_eff;
  logic [AW-1:0] x;
  logic        last;
  logic [7:0]  dec_byte;
  logic [31:0] plain_word;
  logic [23:0] store_rdata;
  tfpd_pkg::store_req_t store_req;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i;

  // A register write takes the cycle; no byte transfers beside it.
  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = (!s1_valid_q || s1_advance) && !cfg_valid_i;
  assign accept     = in_valid_i && in_ready_o;

  // Effective row width: zero acts as one, oversize clamps to the store depth.
  always_comb begin
    if (row_samples_q == '0) begin
      width_eff = WW'(1);
    end else if (CW'(row_samples_q) > CW'(MAX_ROW_SAMPLES)) begin
      width_eff = WW'(MAX_ROW_SAMPLES);
    end else begin
      width_eff = WW'(row_samples_q);
    end
  end

  always_comb begin
    x = ((WW + 1)'(pos_q) >= (WW + 1)'(width_eff)) ? '0 : pos_q;
    last = (((WW + 1)'(x) + (WW + 1)'(1)) == (WW + 1)'(width_eff));
    dec_byte = data_byte_i + prev_byte_q;
    if (msb_first_q) begin
      plain_word = {gather_q[7:0], gather_q[15:8], gather_q[23:16], data_byte_i};
    end else begin
      plain_word = {data_byte_i, gather_q};
    end
    result = (plane_q == tfpd_pkg::PLANE_LAST);
  end

  always_comb begin
    store_req.wr_en = accept && use_pred_q && (plane_q != tfpd_pkg::PLANE_LAST);
    store_req.rd_en = accept && use_pred_q && (plane_q == tfpd_pkg::PLANE_LAST);
    store_req.plane = plane_q;
  end

  // Next row state for a transfer.
  always_comb begin
    prev_byte_d = prev_byte_q;
    plane_d     = plane_q;
    pos_d       = pos_q;
    gather_d    = gather_q;
    if (use_pred_q) begin
      prev_byte_d = dec_byte;
      if (last) begin
        pos_d = '0;
        if (plane_q == tfpd_pkg::PLANE_LAST) begin
          plane_d     = tfpd_pkg::PLANE_TOP;
          prev_byte_d = '0;
        end else begin
          plane_d = plane_q + 2'd1;
        end
      end else begin
        pos_d = x + AW'(1);
      end
    end else begin
      if (plane_q != tfpd_pkg::PLANE_LAST) begin
        case (plane_q)
          tfpd_pkg::PLANE_TOP: gather_d[7:0]   = data_byte_i;
          tfpd_pkg::PLANE_MID: gather_d[15:8]  = data_byte_i;
          default:             gather_d[23:16] = data_byte_i;
        endcase
        plane_d = plane_q + 2'd1;
        pos_d   = x;
      end else begin
        gather_d = '0;
        plane_d  = tfpd_pkg::PLANE_TOP;
        pos_d    = last ? '0 : x + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_samples_q <= tfpd_pkg::ROW_SAMPLES_RESET;
      use_pred_q    <= 1'b0;
      msb_first_q   <= 1'b0;
      prev_byte_q   <= '0;
      plane_q       <= tfpd_pkg::PLANE_TOP;
      pos_q         <= '0;
      gather_q      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index_i)
        tfpd_pkg::CFG_ROW_SAMPLES: row_samples_q <= cfg_data_i;
        tfpd_pkg::CFG_USE_PRED:    use_pred_q    <= cfg_data_i[0];
        tfpd_pkg::CFG_BYTE_ORDER:  msb_first_q   <= cfg_data_i[0];
        default: ;
      endcase
      // Any register write restarts the row; writes beyond the list do nothing.
      if (cfg_index_i != tfpd_pkg::CFG_SPARE) begin
        prev_byte_q <= '0;
        plane_q     <= tfpd_pkg::PLANE_TOP;
        pos_q       <= '0;
        gather_q    <= '0;
      end
    end else if (accept) begin
      prev_byte_q <= prev_byte_d;
      plane_q     <= plane_d;
      pos_q       <= pos_d;
      gather_q    <= gather_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= result;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pred_q <= use_pred_q;
      s1_last_q <= last;
      s1_word_q <= use_pred_q ? {24'd0, dec_byte} : plain_word;
    end
    if (s1_advance) begin
      sample_q  <= s1_pred_q ? {store_rdata, s1_word_q[7:0]} : s1_word_q;
      row_end_q <= s1_last_q;
    end
  end

  tfpd_plane_store #(
    .Depth     (MAX_ROW_SAMPLES),
    .AddrWidth (AW)
  ) u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .addr_i  (x),
    .data_i  (dec_byte),
    .rdata_o (store_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign sample_bits_o = sample_q;
  assign row_end_o     = row_end_q;

endmodule

>>> sv/tfpd_checker.sv
// Port-level checks for the floating-point predictor decoder.
// Bound to tiff_float_predictor_decode; depends on tfpd_pkg for port widths.
module tfpd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [7:0]                         data_byte_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [31:0]                        sample_bits_o,
  input logic                               row_end_o,
  input logic                               cfg_valid_i,
  input logic                               cfg_ready_o,
  input logic [tfpd_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input logic [tfpd_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  // The input side only stalls for a register write or a finished result waiting on the output.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (cfg_valid_i || (out_valid_o && !out_ready_i)))
    else $error("input stalled without a waiting result");

  // A new result appears only after an input transfer, through the read stage and the output register.
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a matching input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(sample_bits_o) && $stable(row_end_o)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result present right after reset");

endmodule

bind tiff_float_predictor_decode tfpd_checker u_tfpd_checker (.*);

>>> tb/tfpd_sample_check.sv
// Checker for tiff_float_predictor_decode: watches the byte, result and register
// channels, predicts every sample word from the accepted bytes and compares.
// Depends on tfpd_pkg for register indexes, plane codes and the row size.
module tfpd_sample_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] sample_bits_i,
  input  logic        row_end_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [tfpd_pkg::CfgIndexWidth-1:0] cfg_index_i,
  input  logic [tfpd_pkg::CfgDataWidth-1:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int SlotBits = $clog2(tfpd_pkg::MaxRowSamples);

  typedef struct packed {
    logic [31:0] bits;
    logic        row_end;
  } sample_t;

  sample_t expected_samples[$];
  sample_t want;
  int      failures;
  int      checked;

  logic [tfpd_pkg::RowSamplesWidth-1:0] row_len_q;
  logic                                 pred_on;
  logic                                 msb_first;

  logic [23:0] upper_bytes [tfpd_pkg::MaxRowSamples];
  logic [7:0]  last_byte;
  logic [1:0]  plane;
  int unsigned column;
  logic [23:0] partial_word;

  function automatic void rewind_row();
    last_byte    = '0;
    plane        = tfpd_pkg::PLANE_TOP;
    column       = 0;
    partial_word = '0;
  endfunction

  function automatic void write_register(input logic [tfpd_pkg::CfgIndexWidth-1:0] idx,
                                         input logic [tfpd_pkg::CfgDataWidth-1:0] data);
    case (idx)
      tfpd_pkg::CFG_ROW_SAMPLES: begin
        row_len_q = data[tfpd_pkg::RowSamplesWidth-1:0];
        rewind_row();
      end
      tfpd_pkg::CFG_USE_PRED: begin
        pred_on = data[0];
        rewind_row();
      end
      tfpd_pkg::CFG_BYTE_ORDER: begin
        msb_first = data[0];
        rewind_row();
      end
      default: ;
    endcase
  endfunction

  // Works out the sample, if any, that one accepted byte completes.
  function automatic void decode_byte(input logic [7:0] b);
    int unsigned width;
    int unsigned x;
    logic [SlotBits-1:0] slot;
    logic        last;
    logic [7:0]  d;
    sample_t     s;
    if (row_len_q == 0) width = 1;
    else if (row_len_q > tfpd_pkg::MaxRowSamples) width = tfpd_pkg::MaxRowSamples;
    else width = 32'(row_len_q);
    x = (column >= width) ? 0 : column;
    slot = SlotBits'(x);
    last = (x + 1 == width);
    if (pred_on) begin
      d = b + last_byte;
      last_byte = d;
      case (plane)
        tfpd_pkg::PLANE_TOP: upper_bytes[slot] = {d, 16'h0000};
        tfpd_pkg::PLANE_MID: upper_bytes[slot][15:8] = d;
        tfpd_pkg::PLANE_LOW: upper_bytes[slot][7:0] = d;
        default: begin
          s.bits = {upper_bytes[slot], d};
          s.row_end = last;
          expected_samples = {expected_samples, s};
        end
      endcase
      if (last) begin
        column = 0;
        // The row restarts its running sum only after the last plane.
        if (plane == tfpd_pkg::PLANE_LAST) begin
          plane = tfpd_pkg::PLANE_TOP;
          last_byte = '0;
        end else begin
          plane = plane + 1'b1;
        end
      end else begin
        column = x + 1;
      end
    end else begin
      if (plane != tfpd_pkg::PLANE_LAST) begin
        partial_word[8*plane +: 8] = b;
        plane = plane + 1'b1;
        column = x;
      end else begin
        if (msb_first) begin
          s.bits = {partial_word[7:0], partial_word[15:8], partial_word[23:16], b};
        end else begin
          s.bits = {b, partial_word};
        end
        s.row_end = last;
        expected_samples = {expected_samples, s};
        partial_word = '0;
        plane = tfpd_pkg::PLANE_TOP;
        column = last ? 0 : x + 1;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_samples.delete();
      failures = 0;
      checked = 0;
      row_len_q = tfpd_pkg::ROW_SAMPLES_RESET;
      pred_on = 1'b0;
      msb_first = 1'b0;
      rewind_row();
    end else begin
      // Results leave through the read stage and output register after their byte, so checking first is safe.
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample: sample_bits %h row_end %b", sample_bits_i, row_end_i);
          failures++;
        end else begin
          want = expected_samples.pop_front();
          checked++;
          if (sample_bits_i !== want.bits) begin
            $error("sample_bits: expected %h, actual %h", want.bits, sample_bits_i);
            failures++;
          end
          if (row_end_i !== want.row_end) begin
            $error("row_end: expected %b, actual %b", want.row_end, row_end_i);
            failures++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) write_register(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_i) decode_byte(data_byte_i);
    end
    fail_count_o <= failures;
    pending_o    <= expected_samples.size();
    checked_o    <= checked;
  end

endmodule

>>> tb/testbench.sv
// Top of the testbench for tiff_float_predictor_decode: clock, reset, byte and
// register stimulus, and the verdict. Depends on tfpd_pkg and tfpd_sample_check.
module testbench;

  localparam int CycleLimit = 200000;
  localparam int SettleCycles = 4;
  localparam int RandomBytes = 376;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_ready_o;
  logic [7:0]                           data_byte_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic [31:0]                          sample_bits_o;
  logic                                 row_end_o;
  logic                                 cfg_valid_i = 1'b0;
  logic                                 cfg_ready_o;
  logic [tfpd_pkg::CfgIndexWidth-1:0]   cfg_index_i = '0;
  logic [tfpd_pkg::CfgDataWidth-1:0]    cfg_data_i = '0;

  int fail_count;
  int pending;
  int checked;
  int cycles = 0;
  int byte_count = 0;
  int setting_count = 0;
  bit steady = 1'b0;

  tiff_float_predictor_decode dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_bits_o(sample_bits_o),
    .row_end_o    (row_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  tfpd_sample_check sample_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_bits_i(sample_bits_o),
    .row_end_i    (row_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 7);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d samples still expected", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (!steady) begin
      while ($urandom_range(99) < 7) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    byte_count++;
  endtask

  // Waits until every predicted sample has arrived, then lets the pipeline settle
  // for bytes that complete no word.
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [tfpd_pkg::CfgIndexWidth-1:0] idx,
                           input logic [tfpd_pkg::CfgDataWidth-1:0] data);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    setting_count++;
  endtask

  initial begin
    logic [tfpd_pkg::CfgIndexWidth-1:0] order [3];
    logic [tfpd_pkg::CfgIndexWidth-1:0] idx;
    logic [tfpd_pkg::CfgDataWidth-1:0]  data;
    int unsigned width;
    int unsigned eff;
    int unsigned count;
    int unsigned first;
    int unsigned pick;
    int random_bytes;
    bit pred;
    bit be;

    order[0] = tfpd_pkg::CFG_ROW_SAMPLES;
    order[1] = tfpd_pkg::CFG_USE_PRED;
    order[2] = tfpd_pkg::CFG_BYTE_ORDER;
    random_bytes = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: plain little-endian words in a 512-sample row.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h01);
    push_byte(8'h7F);
    push_byte(8'h55);
    push_byte(8'hAA);
    push_byte(8'hFE);

    // Big-endian words, one sample per row; a write to the spare index
    // in the middle of a word must leave the word intact.
    write_reg(tfpd_pkg::CFG_ROW_SAMPLES, 10'd1);
    write_reg(tfpd_pkg::CFG_BYTE_ORDER, 10'd1);
    push_byte(8'h12);
    push_byte(8'h34);
    write_reg(tfpd_pkg::CFG_SPARE, 10'h3FF);
    push_byte(8'h56);
    push_byte(8'h78);

    // Predictor with a zero row width, which acts as one sample; the sums wrap.
    write_reg(tfpd_pkg::CFG_USE_PRED, 10'd1);
    write_reg(tfpd_pkg::CFG_ROW_SAMPLES, 10'd0);
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(8'h80);
    push_byte(8'h7F);

    // Two samples per row: planes interleave across the store.
    write_reg(tfpd_pkg::CFG_ROW_SAMPLES, 10'd2);
    push_byte(8'h3F);
    push_byte(8'hC0);
    push_byte(8'h80);
    push_byte(8'h00);
    push_byte(8'h01);
    push_byte(8'hFF);
    push_byte(8'h10);
    push_byte(8'h20);

    while (random_bytes < RandomBytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        width = $urandom_range(1, 8);
      end else if (pick < 90) begin
        width = $urandom_range(9, 40);
      end else begin
        case ($urandom_range(3))
          0: width = 0;
          1: width = 512;
          2: width = 1023;
          default: width = $urandom_range(41, 1023);
        endcase
      end
      eff = (width == 0) ? 1 :
            ((width > tfpd_pkg::MaxRowSamples) ? tfpd_pkg::MaxRowSamples : width);
      pred = ($urandom_range(99) < 60);
      be = ($urandom_range(1) == 1);

      first = $urandom_range(2);
      for (int k = 0; k < 3; k++) begin
        idx = order[2'((first + k) % 3)];
        case (idx)
          tfpd_pkg::CFG_ROW_SAMPLES: data = tfpd_pkg::CfgDataWidth'(width);
          tfpd_pkg::CFG_USE_PRED:    data = tfpd_pkg::CfgDataWidth'(pred);
          default:                   data = tfpd_pkg::CfgDataWidth'(be);
        endcase
        write_reg(idx, data);
      end
      if ($urandom_range(9) == 0) begin
        write_reg(tfpd_pkg::CFG_SPARE, tfpd_pkg::CfgDataWidth'($urandom_range(1023)));
      end

      // Mostly whole rows or words; some phases end mid-row or are short noise.
      if ($urandom_range(9) == 0) begin
        count = $urandom_range(1, 11);
      end else if (eff > 40) begin
        count = $urandom_range(8, 40);
      end else if (pred) begin
        count = 4 * eff * $urandom_range(1, 3);
        if ($urandom_range(3) == 0) count += $urandom_range(0, 4 * eff - 1);
      end else begin
        count = 4 * $urandom_range(2, 12);
        if ($urandom_range(3) == 0) count += $urandom_range(1, 3);
      end

      for (int unsigned i = 0; i < count && random_bytes < RandomBytes; i++) begin
        steady = (random_bytes >= 120 && random_bytes < 260);
        push_byte(8'($urandom_range(255)));
        random_bytes++;
      end
    end
    steady = 1'b0;

    wait_quiet();
    repeat (SettleCycles) @(posedge clk_i);

    $display("covered %0d bytes over %0d register transfers, %0d samples compared",
             byte_count, setting_count, checked);
    $display("row widths from zero to out of range, predictor and both plain byte orders");
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/tfpd_pkg.sv
sv/tfpd_plane_store.sv
sv/tiff_float_predictor_decode.sv
sv/tfpd_checker.sv
tb/tfpd_sample_check.sv
tb/testbench.sv
